[rtl/core/double_ended_queue_with_reverse_core_defines.svh]
// assertion macros used by the deque back end
`ifndef DOUBLE_ENDED_QUEUE_WITH_REVERSE_CORE_DEFINES_SVH
`define DOUBLE_ENDED_QUEUE_WITH_REVERSE_CORE_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication, checked on clk outside reset
`define DEQ_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("deq check failed");
// next-cycle implication, checked on clk outside reset
`define DEQ_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("deq check failed");
`else
`define DEQ_ASSERT_NOW(lbl, ante, cons)
`define DEQ_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

[rtl/core/deq_pkg.sv]
// shared types, codes and defaults for the deque core
package deq_pkg;

  // default ring depth
  localparam int DEQ_DEPTH = 16;
  // entries in the command queue between front and back
  localparam int DEQ_CQ_DEPTH = 2;

  // operation codes
  localparam logic [2:0] OP_PUSH_FRONT = 3'd0;
  localparam logic [2:0] OP_PUSH_BACK  = 3'd1;
  localparam logic [2:0] OP_POP_FRONT  = 3'd2;
  localparam logic [2:0] OP_POP_BACK   = 3'd3;
  localparam logic [2:0] OP_READ_ALL   = 3'd4;
  localparam logic [2:0] OP_REVERSE    = 3'd5;

  // status codes
  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_EMPTY = 2'd1;
  localparam logic [1:0] STAT_FULL  = 2'd2;

  // command kinds after classification
  localparam logic [1:0] CMD_PUSH = 2'd0;
  localparam logic [1:0] CMD_POP  = 2'd1;
  localparam logic [1:0] CMD_READ = 2'd2;
  localparam logic [1:0] CMD_REV  = 2'd3;

  typedef struct packed {
    logic [2:0]         operation;
    logic signed [31:0] value;
  } deq_in_t;

  typedef struct packed {
    logic signed [31:0] result_value;
    logic [1:0]         status;
    logic               last;
  } deq_out_t;

  typedef struct packed {
    logic [1:0]         kind;
    logic               at_front;
    logic signed [31:0] value;
  } deq_cmd_t;

endpackage

[rtl/core/deq_front.sv]
// front end: accepts input items and classifies them into commands
module deq_front import deq_pkg::*; (
  input  logic     push,
  input  logic     full,
  input  deq_in_t  in_data,
  output logic     cmd_wr,
  output deq_cmd_t cmd
);

  logic op_ok;

  // decode operation into command kind and logical end
  always_comb begin
    op_ok        = 1'b1;
    cmd.kind     = CMD_PUSH;
    cmd.at_front = 1'b0;
    cmd.value    = in_data.value;
    unique case (in_data.operation)
      OP_PUSH_FRONT: begin
        cmd.kind     = CMD_PUSH;
        cmd.at_front = 1'b1;
      end
      OP_PUSH_BACK: cmd.kind = CMD_PUSH;
      OP_POP_FRONT: begin
        cmd.kind     = CMD_POP;
        cmd.at_front = 1'b1;
      end
      OP_POP_BACK: cmd.kind = CMD_POP;
      OP_READ_ALL: cmd.kind = CMD_READ;
      OP_REVERSE:  cmd.kind = CMD_REV;
      default:     op_ok    = 1'b0;
    endcase
  end

  // unused codes are accepted and dropped
  assign cmd_wr = push && !full && op_ok;

endmodule

[rtl/core/deq_cmd_queue.sv]
// short command queue between the front and back ends
module deq_cmd_queue import deq_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     wr_en,
  input  deq_cmd_t wr_cmd,
  output logic     full,
  output logic     rd_valid,
  input  logic     rd_en,
  output deq_cmd_t rd_cmd
);

  localparam int PTR_W = (DEQ_CQ_DEPTH > 1) ? $clog2(DEQ_CQ_DEPTH) : 1;
  localparam int CNT_W = $clog2(DEQ_CQ_DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEQ_CQ_DEPTH - 1);

  deq_cmd_t         ent_r [DEQ_CQ_DEPTH];
  logic [PTR_W-1:0] wptr_r, wptr_nxt;
  logic [PTR_W-1:0] rptr_r, rptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_wr, do_rd;

  assign full     = cnt_r == CNT_W'(DEQ_CQ_DEPTH);
  assign rd_valid = cnt_r != '0;
  assign rd_cmd   = ent_r[rptr_r];
  assign do_wr    = wr_en && !full;
  assign do_rd    = rd_en && rd_valid;

  // pointer and fill count update
  always_comb begin
    wptr_nxt = wptr_r;
    rptr_nxt = rptr_r;
    cnt_nxt  = cnt_r;
    if (do_wr) begin
      wptr_nxt = (wptr_r == PTR_LAST) ? '0 : wptr_r + PTR_W'(1);
    end
    if (do_rd) begin
      rptr_nxt = (rptr_r == PTR_LAST) ? '0 : rptr_r + PTR_W'(1);
    end
    if (do_wr && !do_rd) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (do_rd && !do_wr) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (do_wr) begin
      ent_r[wptr_r] <= wr_cmd;
    end
  end

endmodule

[rtl/core/deq_back.sv]
// back end: ring store, deque state, command sequencing and result register
`include "double_ended_queue_with_reverse_core_defines.svh"
module deq_back import deq_pkg::*; #(
  parameter int DEPTH = DEQ_DEPTH
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     cmd_valid,
  input  deq_cmd_t cmd,
  output logic     cmd_rd,
  output logic     empty,
  input  logic     pop,
  output deq_out_t out_data
);

  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [IDX_W:0]   SUM_DEPTH = (IDX_W + 1)'(DEPTH);
  localparam logic [IDX_W-1:0] IDX_LAST  = IDX_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL  = CNT_W'(DEPTH);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_POP  = 2'd1;
  localparam logic [1:0] ST_READ = 2'd2;

  logic [1:0]         st_r, st_nxt;
  logic [IDX_W-1:0]   front_r, front_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic               rev_r, rev_nxt;
  logic [IDX_W-1:0]   i_r, i_nxt;
  logic               out_valid_r, out_valid_nxt;
  deq_out_t           out_data_r, out_data_nxt;

  logic signed [31:0] mem [DEPTH];
  logic signed [31:0] rd_data_r;
  logic               rd_en, wr_en;
  logic [IDX_W-1:0]   rd_addr, wr_addr;

  logic               out_free, is_full, is_empty, phys_front, read_last;
  logic [IDX_W-1:0]   front_inc, front_dec;
  logic [CNT_W-1:0]   count_dec;

  // ring position of base plus offset, both below depth
  function automatic logic [IDX_W-1:0] ring_add(input logic [IDX_W-1:0] base,
                                                input logic [IDX_W-1:0] off);
    logic [IDX_W:0] s;
    s = {1'b0, base} + {1'b0, off};
    if (s >= SUM_DEPTH) begin
      s = s - SUM_DEPTH;
    end
    return s[IDX_W-1:0];
  endfunction

  // ring position of logical element idx
  function automatic logic [IDX_W-1:0] read_slot(input logic [IDX_W-1:0] idx,
                                                 input logic             rev,
                                                 input logic [IDX_W-1:0] fr,
                                                 input logic [CNT_W-1:0] cnt);
    logic [CNT_W-1:0] o;
    o = rev ? (cnt - CNT_W'(1) - CNT_W'(idx)) : CNT_W'(idx);
    return ring_add(fr, o[IDX_W-1:0]);
  endfunction

  assign is_full    = count_r == CNT_FULL;
  assign is_empty   = count_r == '0;
  assign count_dec  = count_r - CNT_W'(1);
  assign front_inc  = (front_r == IDX_LAST) ? '0 : front_r + IDX_W'(1);
  assign front_dec  = (front_r == '0) ? IDX_LAST : front_r - IDX_W'(1);
  assign phys_front = cmd.at_front != rev_r;
  assign read_last  = CNT_W'(i_r) == count_dec;
  assign out_free   = !out_valid_r || pop;

  assign empty    = !out_valid_r;
  assign out_data = out_data_r;

  // command sequencing
  always_comb begin
    st_nxt        = st_r;
    front_nxt     = front_r;
    count_nxt     = count_r;
    rev_nxt       = rev_r;
    i_nxt         = i_r;
    out_valid_nxt = out_valid_r && !pop;
    out_data_nxt  = out_data_r;
    cmd_rd        = 1'b0;
    rd_en         = 1'b0;
    wr_en         = 1'b0;
    rd_addr       = front_r;
    wr_addr       = front_r;
    unique case (st_r)
      ST_IDLE: begin
        if (cmd_valid && out_free) begin
          cmd_rd = 1'b1;
          unique case (cmd.kind)
            CMD_PUSH: begin
              out_valid_nxt = 1'b1;
              out_data_nxt  = '{result_value: '0, status: STAT_OK, last: 1'b1};
              if (is_full) begin
                out_data_nxt.status = STAT_FULL;
              end else begin
                wr_en     = 1'b1;
                count_nxt = count_r + CNT_W'(1);
                if (phys_front) begin
                  front_nxt = front_dec;
                  wr_addr   = front_dec;
                end else begin
                  wr_addr = ring_add(front_r, count_r[IDX_W-1:0]);
                end
              end
            end
            CMD_POP: begin
              if (is_empty) begin
                out_valid_nxt = 1'b1;
                out_data_nxt  = '{result_value: '0, status: STAT_EMPTY, last: 1'b1};
              end else begin
                rd_en     = 1'b1;
                count_nxt = count_dec;
                st_nxt    = ST_POP;
                if (phys_front) begin
                  rd_addr   = front_r;
                  front_nxt = front_inc;
                end else begin
                  rd_addr = ring_add(front_r, count_dec[IDX_W-1:0]);
                end
              end
            end
            CMD_READ: begin
              if (is_empty) begin
                out_valid_nxt = 1'b1;
                out_data_nxt  = '{result_value: '0, status: STAT_EMPTY, last: 1'b1};
              end else begin
                rd_en   = 1'b1;
                i_nxt   = '0;
                rd_addr = read_slot('0, rev_r, front_r, count_r);
                st_nxt  = ST_READ;
              end
            end
            CMD_REV: begin
              rev_nxt       = !rev_r;
              out_valid_nxt = 1'b1;
              out_data_nxt  = '{result_value: '0, status: STAT_OK, last: 1'b1};
            end
          endcase
        end
      end
      ST_POP: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = '{result_value: rd_data_r, status: STAT_OK, last: 1'b1};
          st_nxt        = ST_IDLE;
        end
      end
      ST_READ: begin
        // one element per transfer, next address read while emitting
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = '{result_value: rd_data_r, status: STAT_OK,
                            last: read_last};
          if (read_last) begin
            st_nxt = ST_IDLE;
          end else begin
            i_nxt   = i_r + IDX_W'(1);
            rd_en   = 1'b1;
            rd_addr = read_slot(i_r + IDX_W'(1), rev_r, front_r, count_r);
          end
        end
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      front_r     <= '0;
      count_r     <= '0;
      rev_r       <= 1'b0;
      i_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      front_r     <= front_nxt;
      count_r     <= count_nxt;
      rev_r       <= rev_nxt;
      i_r         <= i_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  // ring store, one write and one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= cmd.value;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  // checks
  `DEQ_ASSERT_NOW(a_count_bound, 1'b1, count_r <= CNT_FULL)
  `DEQ_ASSERT_NOW(a_read_index, st_r == ST_READ, CNT_W'(i_r) < count_r)
  `DEQ_ASSERT_NEXT(a_read_stable, st_r == ST_READ || st_r == ST_POP, $stable(count_r))
  `DEQ_ASSERT_NOW(a_err_zero, out_valid_r && out_data_r.status != STAT_OK,
                  out_data_r.result_value == 32'sd0 && out_data_r.last)
  `DEQ_ASSERT_NEXT(a_pop_result, st_r == ST_POP && out_free, out_valid_r)

endmodule

[rtl/core/double_ended_queue_with_reverse_core.sv]
// top level of the deque core: front end, command queue and back end
//
//   channel   direction  handshake           payload
//   input     in         push / full         in_data   (deq_in_t)
//   result    out        empty / pop         out_data  (deq_out_t)
//
// an accepted item is registered in the two-entry command queue
// push, reverse and every error case then load the result register from idle
// pop with data makes a ring store read, then the result load; read all starts
// with a read and sends one element per transfer from the registered read port
// a held result stalls the back end, and the command queue then fills and
// raises full; reset clears indexes, count, order and queues, not the ring store
module double_ended_queue_with_reverse_core import deq_pkg::*; #(
  parameter int DEPTH = DEQ_DEPTH
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  output logic     full,
  input  deq_in_t  in_data,
  output logic     empty,
  input  logic     pop,
  output deq_out_t out_data
);

  logic     cq_wr, cq_full, cq_valid, cq_rd;
  deq_cmd_t cq_wr_cmd, cq_rd_cmd;

  assign full = cq_full;

  // classify accepted items
  deq_front u_front (
    .push    (push),
    .full    (cq_full),
    .in_data (in_data),
    .cmd_wr  (cq_wr),
    .cmd     (cq_wr_cmd)
  );

  // decouple front and back
  deq_cmd_queue u_cmd_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cq_wr),
    .wr_cmd   (cq_wr_cmd),
    .full     (cq_full),
    .rd_valid (cq_valid),
    .rd_en    (cq_rd),
    .rd_cmd   (cq_rd_cmd)
  );

  // execute commands and hold results
  deq_back #(
    .DEPTH (DEPTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cq_valid),
    .cmd       (cq_rd_cmd),
    .cmd_rd    (cq_rd),
    .empty     (empty),
    .pop       (pop),
    .out_data  (out_data)
  );

endmodule

[tb/tb.sv]
// self-checking testbench for the deque core: directed and random command traffic
`timescale 1ns / 1ps

module tb;
  import deq_pkg::*;

  // codes the core must ignore
  localparam logic [2:0] OP_SPARE_6 = 3'd6;
  localparam logic [2:0] OP_SPARE_7 = 3'd7;
  localparam int RANDOM_ITEMS = 150;
  localparam int CALM_TAIL = 40;

  typedef enum {MODE_FILL, MODE_DRAIN, MODE_MIXED} traffic_mode_t;

  // deque predictor and result checker
  class deque_scoreboard;
    logic signed [31:0] ring[DEQ_DEPTH];
    int unsigned head;
    int unsigned count;
    bit flipped;
    deq_out_t pending[$];
    int errors;

    function void add_result(logic signed [31:0] v, logic [1:0] st, logic lst);
      deq_out_t r;
      r.result_value = v;
      r.status = st;
      r.last = lst;
      pending.push_back(r);
    endfunction

    // work out the results of one accepted command
    function void note_command(deq_in_t it);
      bit at_head;
      int unsigned slot;
      int unsigned phys;
      case (it.operation) inside
        OP_PUSH_FRONT, OP_PUSH_BACK: begin
          if (count >= DEQ_DEPTH) begin
            add_result('0, STAT_FULL, 1'b1);
          end else begin
            at_head = (it.operation == OP_PUSH_FRONT) != flipped;
            if (at_head) begin
              head = (head + DEQ_DEPTH - 1) % DEQ_DEPTH;
              ring[head] = it.value;
            end else begin
              ring[(head + count) % DEQ_DEPTH] = it.value;
            end
            count++;
            add_result('0, STAT_OK, 1'b1);
          end
        end
        OP_POP_FRONT, OP_POP_BACK: begin
          if (count == 0) begin
            add_result('0, STAT_EMPTY, 1'b1);
          end else begin
            at_head = (it.operation == OP_POP_FRONT) != flipped;
            if (at_head) begin
              slot = head;
              head = (head + 1) % DEQ_DEPTH;
            end else begin
              slot = (head + count - 1) % DEQ_DEPTH;
            end
            count--;
            add_result(ring[slot], STAT_OK, 1'b1);
          end
        end
        OP_READ_ALL: begin
          if (count == 0) begin
            add_result('0, STAT_EMPTY, 1'b1);
          end else begin
            for (int unsigned i = 0; i < count; i++) begin
              phys = flipped ? (count - 1 - i) : i;
              add_result(ring[(head + phys) % DEQ_DEPTH], STAT_OK, i + 1 == count);
            end
          end
        end
        OP_REVERSE: begin
          flipped = !flipped;
          add_result('0, STAT_OK, 1'b1);
        end
        default: ;
      endcase
    endfunction

    // compare one result transfer with the oldest expectation
    function void check_result(deq_out_t got);
      deq_out_t want;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result: value %0d status %0d last %0b",
                 $time, got.result_value, got.status, got.last);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got.result_value !== want.result_value) begin
        $display("%0t: result_value mismatch: expected %0d, actual %0d",
                 $time, want.result_value, got.result_value);
        errors++;
      end
      if (got.status !== want.status) begin
        $display("%0t: status mismatch: expected %0d, actual %0d",
                 $time, want.status, got.status);
        errors++;
      end
      if (got.last !== want.last) begin
        $display("%0t: last mismatch: expected %0b, actual %0b",
                 $time, want.last, got.last);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic push;
  logic full;
  deq_in_t in_data;
  logic empty;
  logic pop;
  deq_out_t out_data;

  deque_scoreboard sb;
  bit idling;
  int stall_left;

  double_ended_queue_with_reverse_core #(.DEPTH(DEQ_DEPTH)) uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .full     (full),
    .in_data  (in_data),
    .empty    (empty),
    .pop      (pop),
    .out_data (out_data)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // watchdog
  initial begin
    #5_000_000;
    $display("double_ended_queue_with_reverse_core regression: fail");
    $finish;
  end

  // transfer monitor on both channels
  always @(posedge clk) begin
    if (rst_n) begin
      if (push && !full) sb.note_command(in_data);
      if (pop && !empty) sb.check_result(out_data);
    end
  end

  // result side: random stall bursts while idling is on
  initial begin
    pop = 1'b0;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (!rst_n) begin
        pop <= 1'b0;
      end else if (stall_left > 0) begin
        pop <= 1'b0;
        stall_left--;
      end else if (idling && $urandom_range(0, 4) == 0) begin
        pop <= 1'b0;
        stall_left = $urandom_range(1, 4) - 1;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  // one command transfer, entered and left at a falling edge
  task automatic send_item(input logic [2:0] op, input logic signed [31:0] v);
    deq_in_t it;
    it.operation = op;
    it.value = v;
    if (idling && $urandom_range(0, 3) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    push <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (full) @(posedge clk);
    @(negedge clk);
  endtask

  // values biased toward the extremes
  function automatic logic signed [31:0] pick_value();
    case ($urandom_range(0, 7))
      0: return 32'sh8000_0000;
      1: return 32'sh7fff_ffff;
      2: return '0;
      3: return -32'sd1;
      default: return $urandom;
    endcase
  endfunction

  // operation mix for each traffic mode
  function automatic logic [2:0] pick_op(traffic_mode_t mode);
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 4) return $urandom_range(0, 1) ? OP_SPARE_6 : OP_SPARE_7;
    roll = $urandom_range(0, 9);
    case (mode)
      MODE_FILL: begin
        if (roll < 7) return $urandom_range(0, 1) ? OP_PUSH_FRONT : OP_PUSH_BACK;
        if (roll == 7) return $urandom_range(0, 1) ? OP_POP_FRONT : OP_POP_BACK;
        return roll == 8 ? OP_READ_ALL : OP_REVERSE;
      end
      MODE_DRAIN: begin
        if (roll < 7) return $urandom_range(0, 1) ? OP_POP_FRONT : OP_POP_BACK;
        if (roll == 7) return $urandom_range(0, 1) ? OP_PUSH_FRONT : OP_PUSH_BACK;
        return roll == 8 ? OP_READ_ALL : OP_REVERSE;
      end
      default: return 3'($urandom_range(0, 5));
    endcase
  endfunction

  // stimulus
  initial begin
    int sent;
    int episode_left;
    logic [2:0] op;
    traffic_mode_t mode;

    sb = new;
    rst_n = 1'b0;
    push = 1'b0;
    in_data = '0;
    idling = 1'b1;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: empty cases, spare codes, extremes, order flips
    send_item(OP_POP_FRONT, 32'sd5);
    send_item(OP_POP_BACK, -32'sd5);
    send_item(OP_READ_ALL, '0);
    send_item(OP_REVERSE, '0);
    send_item(OP_SPARE_6, 32'sh7fff_ffff);
    send_item(OP_SPARE_7, 32'sh8000_0000);
    send_item(OP_PUSH_FRONT, 32'sh8000_0000);
    send_item(OP_PUSH_BACK, 32'sh7fff_ffff);
    send_item(OP_PUSH_FRONT, '0);
    send_item(OP_PUSH_BACK, -32'sd1);
    send_item(OP_READ_ALL, '0);
    send_item(OP_REVERSE, '0);
    send_item(OP_READ_ALL, '0);
    send_item(OP_POP_FRONT, '0);
    send_item(OP_POP_BACK, '0);
    send_item(OP_REVERSE, '0);
    send_item(OP_POP_FRONT, '0);
    send_item(OP_POP_BACK, '0);
    send_item(OP_POP_BACK, '0);
    send_item(OP_READ_ALL, '0);

    // fill past full, read in both orders, then drain past empty
    for (int i = 0; i < 18; i++)
      send_item($urandom_range(0, 1) ? OP_PUSH_FRONT : OP_PUSH_BACK, pick_value());
    send_item(OP_READ_ALL, '0);
    send_item(OP_REVERSE, '0);
    send_item(OP_READ_ALL, '0);
    for (int i = 0; i < 18; i++)
      send_item($urandom_range(0, 1) ? OP_POP_FRONT : OP_POP_BACK, pick_value());

    // random episodes of fill, drain and mixed traffic
    sent = 0;
    episode_left = 0;
    mode = MODE_MIXED;
    while (sent < RANDOM_ITEMS) begin
      if (episode_left == 0) begin
        episode_left = $urandom_range(15, 35);
        case ($urandom_range(0, 2))
          0: mode = MODE_FILL;
          1: mode = MODE_DRAIN;
          default: mode = MODE_MIXED;
        endcase
        idling = ($urandom_range(0, 3) != 0);
      end
      if (sent >= RANDOM_ITEMS - CALM_TAIL) idling = 1'b0;
      op = pick_op(mode);
      send_item(op, $urandom_range(0, 1) ? pick_value() : $urandom);
      if (op != OP_SPARE_6 && op != OP_SPARE_7) begin
        sent++;
        episode_left--;
      end
    end
    push <= 1'b0;
    idling = 1'b0;

    // drain outstanding results, then watch for strays
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (DEQ_DEPTH + 8) @(posedge clk);

    if (sb.errors == 0)
      $display("double_ended_queue_with_reverse_core regression: pass");
    else
      $display("double_ended_queue_with_reverse_core regression: fail");
    $finish;
  end

endmodule
